// ===== src/rti_pkg.sv =====
`timescale 1ns / 1ps

package rti_pkg;

    localparam int unsigned SCORE_W       = 31;
    localparam int unsigned LEVEL_W       = 8;
    localparam int unsigned EPISODE_W     = 3;
    localparam int unsigned RANK_W        = 3;
    localparam int unsigned DEPTH_DEFAULT = 8;

    localparam int unsigned S_FIELDS_W = SCORE_W + LEVEL_W + EPISODE_W;
    localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_FIELDS_W = 1 + RANK_W;
    localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture the offered entry
        logic find;    // register the insertion point
        logic commit;  // update the table and the result register
    } cmd_t;

endpackage

// ===== src/ranked_table_insert_core.sv =====
`timescale 1ns / 1ps

// channel | direction | ports                    | contents
// s_      | in        | s_tvalid s_tready s_tdata | offered entry
// m_      | out       | m_tvalid m_tready m_tdata | placement result
//
// An entry is captured at its accepting edge, compared across all slot comparators
// in the find state, and written into the table together with its result in the
// write state, which waits while the result register is full; the state machine
// admits one entry at a time and takes no new transfer until the last is written.
// aresetn (synchronous) clears every slot to zero and empties the result register.
// A stalled m_ side holds the update step until the pending result is taken.

module ranked_table_insert_core #(
    parameter int unsigned TABLE_DEPTH = rti_pkg::DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // new_score[30:0], new_level[38:31], new_episode[41:39], zero pad
    input  logic [rti_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // placed[0], rank[3:1], zero pad
    output logic [rti_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int unsigned LEVEL_LO   = rti_pkg::SCORE_W;
    localparam int unsigned EPISODE_LO = rti_pkg::SCORE_W + rti_pkg::LEVEL_W;

    rti_pkg::cmd_t              cmd;
    logic                       out_placed;
    logic [rti_pkg::RANK_W-1:0] out_rank;

    rti_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    rti_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_score   (s_tdata[rti_pkg::SCORE_W-1:0]),
        .in_level   (s_tdata[EPISODE_LO-1:LEVEL_LO]),
        .in_episode (s_tdata[rti_pkg::S_FIELDS_W-1:EPISODE_LO]),
        .out_placed (out_placed),
        .out_rank   (out_rank)
    );

    assign m_tdata = {{(rti_pkg::M_TDATA_W - rti_pkg::M_FIELDS_W){1'b0}}, out_rank, out_placed};

endmodule

// ===== src/rti_ctrl.sv =====
`timescale 1ns / 1ps

module rti_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output rti_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FIND  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_FIND;
                end
            end
            ST_FIND: begin
                cmd.find   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                // hold until the result register can take the new result
                if (out_free) begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_commit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid_reg)
        else $error("result not presented after commit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid_reg || m_tready))
        else $error("commit over a pending result");

    a_accept_to_find: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_FIND))
        else $error("accepted transfer did not start a search");

endmodule

// ===== src/rti_dpath.sv =====
`timescale 1ns / 1ps

module rti_dpath #(
    parameter int unsigned TABLE_DEPTH = rti_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rti_pkg::cmd_t                 cmd,
    input  logic [rti_pkg::SCORE_W-1:0]   in_score,
    input  logic [rti_pkg::LEVEL_W-1:0]   in_level,
    input  logic [rti_pkg::EPISODE_W-1:0] in_episode,
    output logic                          out_placed,
    output logic [rti_pkg::RANK_W-1:0]    out_rank
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [rti_pkg::SCORE_W-1:0]   score_reg   [TABLE_DEPTH];
    logic [rti_pkg::LEVEL_W-1:0]   level_reg   [TABLE_DEPTH];
    logic [rti_pkg::EPISODE_W-1:0] episode_reg [TABLE_DEPTH];

    logic [rti_pkg::SCORE_W-1:0]   new_score_reg;
    logic [rti_pkg::LEVEL_W-1:0]   new_level_reg;
    logic [rti_pkg::EPISODE_W-1:0] new_episode_reg;

    logic [TABLE_DEPTH-1:0] beats;
    logic [IDX_W-1:0]       pos_next;
    logic                   hit_next;
    logic [IDX_W-1:0]       pos_reg;
    logic                   hit_reg;
    logic                   placed_reg;
    logic [rti_pkg::RANK_W-1:0] rank_reg;
    logic [rti_pkg::RANK_W+IDX_W-1:0] rank_wide;

    // one comparator per slot
    always_comb begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            beats[k] = (new_score_reg > score_reg[k]) ||
                       ((new_score_reg == score_reg[k]) && (new_level_reg > level_reg[k]));
        end
    end

    // first qualifying slot wins
    always_comb begin
        pos_next = '0;
        hit_next = |beats;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
            if (beats[k]) begin
                pos_next = IDX_W'(k);
            end
        end
    end

    assign rank_wide = {{rti_pkg::RANK_W{1'b0}}, pos_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            new_score_reg   <= in_score;
            new_level_reg   <= in_level;
            new_episode_reg <= in_episode;
        end
        if (cmd.find) begin
            pos_reg <= pos_next;
            hit_reg <= hit_next;
        end
        if (cmd.commit) begin
            placed_reg <= hit_reg;
            rank_reg   <= hit_reg ? rank_wide[rti_pkg::RANK_W-1:0] : '0;
        end
    end

    // shift the slots below the insertion point down, drop the last one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                score_reg[k]   <= '0;
                level_reg[k]   <= '0;
                episode_reg[k] <= '0;
            end
        end else if (cmd.commit && hit_reg) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                if (IDX_W'(k) == pos_reg) begin
                    score_reg[k]   <= new_score_reg;
                    level_reg[k]   <= new_level_reg;
                    episode_reg[k] <= new_episode_reg;
                end else if (k > 0 && IDX_W'(k) > pos_reg) begin
                    score_reg[k]   <= score_reg[k-1];
                    level_reg[k]   <= level_reg[k-1];
                    episode_reg[k] <= episode_reg[k-1];
                end
            end
        end
    end

    assign out_placed = placed_reg;
    assign out_rank   = rank_reg;

    a_table_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        score_reg[0] >= score_reg[1])
        else $error("table head out of order");

    a_entry_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && hit_reg) |=> (score_reg[$past(pos_reg)] == $past(new_score_reg)))
        else $error("offered entry not written at its rank");

    a_miss_keeps_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !hit_reg) |=> $stable(score_reg[TABLE_DEPTH-1]))
        else $error("table changed on an entry that was not placed");

endmodule
